/* sv/ssr_pkg.sv */
// shared types and constants of the stream substring replace block
`timescale 1ns / 1ps
package ssr_pkg;

    localparam int MAX_PATTERN_BYTES_DEF = 8;
    localparam int REPL_MAX              = 8;
    localparam int DATA_W                = 64;
    localparam int CNT_W                 = 4;
    localparam int CFG_IDX_W             = 4;
    localparam int QUEUE_DEPTH           = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_BYTES      = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH     = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPLACEMENT_BYTES  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REPLACEMENT_LENGTH = 4'd3;

    // one emit job: cnt bytes of data, lowest byte first
    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic [CNT_W-1:0]  cnt;
        logic              last;
        logic              any;
    } cmd_t;

endpackage

/* sv/stream_substring_replace_core.sv */
// top level of the streaming find-and-replace block
//
// text enters on the s_ channel one byte per word, s_tlast on the final byte
// of a text. results leave on the m_ channel: m_tdata holds the byte,
// m_tuser[0] says a byte is present, m_tuser[1] says on the last word that
// the text had at least one replacement, m_tlast closes the text.
// the cfg channel writes pattern bytes, pattern length, replacement bytes
// and replacement length at indexes 0 to 3; other indexes are ignored.
// cfg_ready is always high; write only while the block is idle.
// a result word passes through the job queue and then the output register.
// throughput: one input word per cycle while results keep pace; an input
// word that causes n results holds the serializer for n words (one for
// an empty closing word), and the two-entry job queue then fills and drops s_tready.
// the output register lets a new word be taken while a result waits.
// a stalled m_tready holds the output word and, once the queue is full,
// the input. reset clears the config registers, window fill and queue.
`timescale 1ns / 1ps
module stream_substring_replace_core #(
    parameter int MAX_PATTERN_BYTES = ssr_pkg::MAX_PATTERN_BYTES_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // text_byte
    input  logic                          s_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [7:0]                    m_tdata,   // out_byte
    output logic                          m_tlast,
    output logic [1:0]                    m_tuser,   // byte_present, any_replaced
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ssr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ssr_pkg::DATA_W-1:0]    cfg_data
);
    import ssr_pkg::*;

    logic q_full, push, pop, head_valid;
    cmd_t push_cmd, head_cmd;

    ssr_front #(
        .MAX_PATTERN_BYTES(MAX_PATTERN_BYTES)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    ssr_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    ssr_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

endmodule

/* sv/ssr_front.sv */
// front end: config registers, match window and classification into emit jobs
`timescale 1ns / 1ps
module ssr_front #(
    parameter int MAX_PATTERN_BYTES = ssr_pkg::MAX_PATTERN_BYTES_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [7:0]                   s_tdata,
    input  logic                         s_tlast,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [ssr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ssr_pkg::DATA_W-1:0]   cfg_data,
    input  logic                         q_full,
    output logic                         push,
    output ssr_pkg::cmd_t                push_cmd
);
    import ssr_pkg::*;

    localparam int FILL_W = $clog2(MAX_PATTERN_BYTES + 1);
    localparam int IDX_W  = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;

    logic [DATA_W-1:0] pat_bytes_reg;
    logic [CNT_W-1:0]  pat_len_reg;
    logic [DATA_W-1:0] rep_bytes_reg;
    logic [CNT_W-1:0]  rep_len_reg;

    logic [7:0]        win_reg [MAX_PATTERN_BYTES];
    logic [7:0]        win_next [MAX_PATTERN_BYTES];
    logic [7:0]        win_new [MAX_PATTERN_BYTES];
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic              seen_reg, seen_next;

    logic [FILL_W-1:0] plen, wsize, fill_eff, fill_inc;
    logic [CNT_W-1:0]  rlen;
    logic              full, hit, accept, cfg_wr;

    assign s_tready  = !q_full;
    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;
    assign cfg_wr    = cfg_valid && cfg_ready;

    always_comb begin
        if (pat_len_reg > CNT_W'(MAX_PATTERN_BYTES)) begin
            plen = FILL_W'(MAX_PATTERN_BYTES);
        end else begin
            plen = FILL_W'(pat_len_reg);
        end
        wsize = (plen == '0) ? FILL_W'(1) : plen;
        rlen  = (rep_len_reg > CNT_W'(REPL_MAX)) ? CNT_W'(REPL_MAX) : rep_len_reg;
    end

    always_comb begin
        logic all_eq;
        fill_eff = (fill_reg >= wsize) ? '0 : fill_reg;
        fill_inc = fill_eff + 1'b1;
        full     = (fill_inc == wsize);
        win_new  = win_reg;
        win_new[fill_eff[IDX_W-1:0]] = s_tdata;
        all_eq = 1'b1;
        for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
            if (FILL_W'(i) < plen && win_new[i] != pat_bytes_reg[8*i +: 8]) begin
                all_eq = 1'b0;
            end
        end
        hit = full && (plen != '0) && all_eq;
    end

    always_comb begin
        push_cmd.data = '0;
        if (hit) begin
            push_cmd.data = rep_bytes_reg;
        end else begin
            for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
                push_cmd.data[8*i +: 8] = win_new[i];
            end
        end
        if (hit) begin
            push_cmd.cnt = rlen;
        end else if (full) begin
            push_cmd.cnt = s_tlast ? CNT_W'(wsize) : CNT_W'(1);
        end else begin
            push_cmd.cnt = s_tlast ? CNT_W'(fill_inc) : '0;
        end
        push_cmd.last = s_tlast;
        push_cmd.any  = seen_reg || hit;
        push = accept && (push_cmd.cnt != '0 || s_tlast);
    end

    always_comb begin
        fill_next = fill_reg;
        seen_next = seen_reg;
        win_next  = win_reg;
        if (accept) begin
            win_next = win_new;
            if (s_tlast || hit) begin
                fill_next = '0;
            end else if (full) begin
                fill_next = wsize - 1'b1;
                for (int i = 0; i < MAX_PATTERN_BYTES - 1; i++) begin
                    win_next[i] = win_new[i + 1];
                end
            end else begin
                fill_next = fill_inc;
            end
            seen_next = s_tlast ? 1'b0 : (seen_reg || hit);
        end
        if (cfg_wr && cfg_index == CFG_PATTERN_LENGTH) begin
            fill_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_bytes_reg <= '0;
            pat_len_reg   <= '0;
            rep_bytes_reg <= '0;
            rep_len_reg   <= '0;
            fill_reg      <= '0;
            seen_reg      <= 1'b0;
        end else begin
            fill_reg <= fill_next;
            seen_reg <= seen_next;
            if (cfg_wr) begin
                unique case (cfg_index)
                    CFG_PATTERN_BYTES:      pat_bytes_reg <= cfg_data;
                    CFG_PATTERN_LENGTH:     pat_len_reg   <= cfg_data[CNT_W-1:0];
                    CFG_REPLACEMENT_BYTES:  rep_bytes_reg <= cfg_data;
                    CFG_REPLACEMENT_LENGTH: rep_len_reg   <= cfg_data[CNT_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // window contents need no reset
    always_ff @(posedge aclk) begin
        win_reg <= win_next;
    end

endmodule

/* sv/ssr_queue.sv */
// short job queue between front end and output serializer
`timescale 1ns / 1ps
module ssr_queue #(
    parameter int DEPTH = ssr_pkg::QUEUE_DEPTH
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  ssr_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          head_valid,
    output ssr_pkg::cmd_t head_cmd
);
    import ssr_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_QW = $clog2(DEPTH + 1);

    cmd_t              mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_QW-1:0] count_reg;
    logic              do_pop;

    assign full       = (count_reg == CNT_QW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = mem_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (do_pop) begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (!push && do_pop) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

/* sv/ssr_back.sv */
// back end: serializes emit jobs into output words through an output register
`timescale 1ns / 1ps
module ssr_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          head_valid,
    input  ssr_pkg::cmd_t head_cmd,
    output logic          pop,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [7:0]    m_tdata,
    output logic          m_tlast,
    output logic [1:0]    m_tuser
);
    import ssr_pkg::*;

    localparam int IDX_W = CNT_W - 1;

    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_last;
    logic             out_valid_reg;
    logic [7:0]       out_byte_reg;
    logic             out_present_reg, out_last_reg, out_any_reg;
    logic             advance, present, at_end;
    logic [CNT_W-1:0] cnt_m1;

    assign present  = (head_cmd.cnt != '0);
    assign cnt_m1   = head_cmd.cnt - 1'b1;
    assign idx_last = present ? cnt_m1[IDX_W-1:0] : '0;
    assign at_end   = (idx_reg == idx_last);
    assign advance  = head_valid && (!out_valid_reg || m_tready);
    assign pop      = advance && at_end;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = {out_any_reg, out_present_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
            idx_reg       <= at_end ? '0 : idx_reg + 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_byte_reg    <= present ? head_cmd.data[{idx_reg, 3'b000} +: 8] : 8'h00;
            out_present_reg <= present;
            out_last_reg    <= head_cmd.last && at_end;
            out_any_reg     <= head_cmd.last && at_end && head_cmd.any;
        end
    end

endmodule

/* sv/ssr_checker.sv */
// port-level checks of the result channel, bound to the top level
`timescale 1ns / 1ps
module ssr_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast,
    input logic [1:0] m_tuser
);

    // a stalled word stays offered
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result word dropped while stalled");

    // an empty word only closes a text
    a_empty_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tlast && m_tdata == 8'h00)
        else $error("empty word not a zero closing word");

    // replacement flag only on the closing word
    a_flag_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !m_tuser[1])
        else $error("replacement flag before end of text");

    // output register empty right after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind stream_substring_replace_core ssr_checker u_ssr_checker (.*);
